// ===== src/bfnms_pkg.sv =====
// ----------------------------------------------------------------------------
// bfnms_pkg: shared types and constants
// Holds the register map, the sequencer states and the register reset values
// used by the anchor filter and suppression block.
// ----------------------------------------------------------------------------
package bfnms_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_PICK,
        ST_EMIT
    } state_t;

    localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_MIN_SIDE        = 3'd1;
    localparam logic [2:0] REG_MAX_SIDE        = 3'd2;
    localparam logic [2:0] REG_IOU_LIMIT       = 3'd3;
    localparam logic [2:0] REG_FRAME_EXTENT    = 3'd4;

    localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd45875;
    localparam logic [13:0] RST_MIN_SIDE        = 14'd410;
    localparam logic [13:0] RST_MAX_SIDE        = 14'd9216;
    localparam logic [7:0]  RST_IOU_LIMIT       = 8'd77;
    localparam logic [13:0] RST_FRAME_EXTENT    = 14'd10240;

    // One stored box: centers, sides and score.
    typedef struct packed {
        logic [13:0] cx;
        logic [13:0] cy;
        logic [13:0] w;
        logic [13:0] h;
        logic [15:0] sc;
    } box_t;

endpackage

// ===== src/box_filter_nms_topk.sv =====
// ----------------------------------------------------------------------------
// box_filter_nms_topk: anchor filter with greedy non-maximum suppression
// Filters anchors into a box store and, on the frame's last anchor, picks up
// to MAX_KEEP boxes in score order, dropping those that overlap a kept box.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_axis   in         one anchor per transaction, tlast ends the frame
// m_axis   out        one kept box per transaction, tlast on the last one
// apb      in/out     five configuration registers at 4*index
//
// Anchors that do not end the frame are taken back to back. The last
// anchor starts up to MAX_KEEP passes over the stored boxes, each closed
// by a read state and a pick state. Each stored box is read, then tested
// against the kept boxes in turn in the shared overlap unit, stopping
// early once suppressed; a box that is itself kept is skipped. Results
// wait in an output register and the block takes no anchor until all
// of them are delivered. The store needs no clearing after reset, since
// only entries written this frame are read.
// ----------------------------------------------------------------------------
module box_filter_nms_topk
    import bfnms_pkg::*;
#(
    parameter int MAX_BOXES = 8192,
    parameter int MAX_KEEP  = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // center_x[14:0], center_y[29:15], box_width[44:30], box_height[59:45],
    // score[75:60], zero fill
    input  logic [79:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kept_center_x[13:0], kept_center_y[27:14], kept_width[41:28],
    // kept_height[55:42], kept_score[71:56]
    output logic [71:0] m_axis_tdata,
    // found[0], overflowed[1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_BOXES);
    localparam int KW = $clog2(MAX_KEEP + 1);
    localparam int SW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    logic [15:0] score_threshold_reg;
    logic [13:0] min_side_reg, max_side_reg, frame_extent_reg;
    logic [7:0]  iou_limit_reg;

    box_t        mem [MAX_BOXES];
    box_t        rd_box_reg;
    logic [AW:0] count_reg;
    logic        ovf_reg;

    state_t      state_reg, state_next;
    logic [AW:0] idx_reg;
    logic [KW-1:0] kept_n_reg;
    logic [SW-1:0] k_reg;
    logic        skip_reg;
    logic        have_reg;
    logic        have_started_reg;
    logic [AW-1:0] best_idx_reg;
    box_t        best_box_reg;
    box_t        kept_box_reg [MAX_KEEP];
    logic [AW-1:0] kept_slot_reg [MAX_KEEP];
    logic [KW-1:0] emit_reg;
    logic        iou_start, iou_done, iou_sup;
    logic        out_valid_reg;
    logic        in_fire, out_fire, cfg_wr;

    logic signed [14:0] in_cx, in_cy, in_w, in_h;
    logic [15:0] in_sc;
    logic        pass_ok;
    box_t        in_box;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_threshold_reg <= RST_SCORE_THRESHOLD;
            min_side_reg        <= RST_MIN_SIDE;
            max_side_reg        <= RST_MAX_SIDE;
            iou_limit_reg       <= RST_IOU_LIMIT;
            frame_extent_reg    <= RST_FRAME_EXTENT;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_SCORE_THRESHOLD: score_threshold_reg <= pwdata[15:0];
                REG_MIN_SIDE:        min_side_reg        <= pwdata[13:0];
                REG_MAX_SIDE:        max_side_reg        <= pwdata[13:0];
                REG_IOU_LIMIT:       iou_limit_reg       <= pwdata[7:0];
                REG_FRAME_EXTENT:    frame_extent_reg    <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_SCORE_THRESHOLD: prdata = {16'b0, score_threshold_reg};
            REG_MIN_SIDE:        prdata = {18'b0, min_side_reg};
            REG_MAX_SIDE:        prdata = {18'b0, max_side_reg};
            REG_IOU_LIMIT:       prdata = {24'b0, iou_limit_reg};
            REG_FRAME_EXTENT:    prdata = {18'b0, frame_extent_reg};
            default:             prdata = 32'b0;
        endcase
    end

    function automatic logic [13:0] clamp(input logic signed [14:0] v, input logic [13:0] hi);
        begin
            if (v[14])
                clamp = 14'd0;
            else if (v[13:0] > hi)
                clamp = hi;
            else
                clamp = v[13:0];
        end
    endfunction

    assign in_cx = s_axis_tdata[14:0];
    assign in_cy = s_axis_tdata[29:15];
    assign in_w  = s_axis_tdata[44:30];
    assign in_h  = s_axis_tdata[59:45];
    assign in_sc = s_axis_tdata[75:60];
    assign pass_ok = (in_sc >= score_threshold_reg)
                     && (in_w >= $signed({1'b0, min_side_reg}))
                     && (in_h >= $signed({1'b0, min_side_reg}))
                     && (in_w <= $signed({1'b0, max_side_reg}))
                     && (in_h <= $signed({1'b0, max_side_reg}));
    assign in_box = '{cx: clamp(in_cx, frame_extent_reg), cy: clamp(in_cy, frame_extent_reg),
                      w: clamp(in_w, frame_extent_reg), h: clamp(in_h, frame_extent_reg),
                      sc: in_sc};

    assign s_axis_tready = (state_reg == ST_LOAD) && !out_valid_reg;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Store write and registered read port.
    always_ff @(posedge clk)
    begin
        if (in_fire && pass_ok && (count_reg < (AW+1)'(MAX_BOXES)))
        begin
            mem[count_reg[AW-1:0]] <= in_box;
        end
        rd_box_reg <= mem[idx_reg[AW-1:0]];
    end

    bfnms_iou u_iou (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (iou_start),
        .box_a      (rd_box_reg),
        .box_b      (kept_box_reg[k_reg]),
        .iou_limit  (iou_limit_reg),
        .done       (iou_done),
        .suppressed (iou_sup)
    );

    logic check_slot;
    logic at_end_k;
    assign at_end_k = ({{(KW-SW){1'b0}}, k_reg} + KW'(1)) >= kept_n_reg;
    assign check_slot = (kept_slot_reg[k_reg] == idx_reg[AW-1:0]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && s_axis_tlast)
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (idx_reg >= count_reg)
                    state_next = ST_PICK;
                else
                    state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                if (kept_n_reg == '0 || skip_reg || (iou_done && (iou_sup || at_end_k)))
                    state_next = ST_SCAN_RD;
            end
            ST_PICK:
            begin
                if (!have_reg || kept_n_reg + KW'(1) >= KW'(MAX_KEEP))
                    state_next = ST_EMIT;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_EMIT:
            begin
                if (out_fire && m_axis_tlast)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // The overlap unit starts at most once per kept box whose slot differs from the box,
    // from idle, so that it captures the current pair of boxes.
    assign iou_start = (state_reg == ST_SCAN_EV) && (kept_n_reg != '0) && !skip_reg
                       && !check_slot && !have_started_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            idx_reg          <= '0;
            kept_n_reg       <= '0;
            k_reg            <= '0;
            skip_reg         <= 1'b0;
            have_reg         <= 1'b0;
            have_started_reg <= 1'b0;
            emit_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire && pass_ok)
                    begin
                        if (count_reg < (AW+1)'(MAX_BOXES))
                            count_reg <= count_reg + (AW+1)'(1);
                        else
                            ovf_reg <= 1'b1;
                    end
                    idx_reg    <= '0;
                    kept_n_reg <= '0;
                    have_reg   <= 1'b0;
                end
                ST_SCAN_RD:
                begin
                    k_reg            <= '0;
                    skip_reg         <= 1'b0;
                    have_started_reg <= 1'b0;
                end
                ST_SCAN_EV:
                begin
                    if (iou_start)
                        have_started_reg <= 1'b1;
                    if (kept_n_reg != '0 && !skip_reg && !have_started_reg && check_slot)
                        skip_reg <= 1'b1;
                    else if (iou_done)
                    begin
                        if (iou_sup)
                            skip_reg <= 1'b1;
                        else if (!at_end_k)
                        begin
                            k_reg <= k_reg + SW'(1);
                            have_started_reg <= 1'b0;
                        end
                    end
                    if (state_next == ST_SCAN_RD)
                    begin
                        if (!(skip_reg || (iou_done && iou_sup))
                            && (!have_reg || rd_box_reg.sc > best_box_reg.sc))
                        begin
                            have_reg     <= 1'b1;
                            best_idx_reg <= idx_reg[AW-1:0];
                            best_box_reg <= rd_box_reg;
                        end
                        idx_reg <= idx_reg + (AW+1)'(1);
                    end
                end
                ST_PICK:
                begin
                    if (have_reg)
                    begin
                        kept_box_reg[kept_n_reg[SW-1:0]]  <= best_box_reg;
                        kept_slot_reg[kept_n_reg[SW-1:0]] <= best_idx_reg;
                        kept_n_reg <= kept_n_reg + KW'(1);
                    end
                    have_reg <= 1'b0;
                    idx_reg  <= '0;
                    emit_reg <= '0;
                    if (state_next == ST_EMIT)
                        out_valid_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (out_fire)
                    begin
                        emit_reg <= emit_reg + KW'(1);
                        if (m_axis_tlast)
                        begin
                            out_valid_reg <= 1'b0;
                            count_reg     <= '0;
                            ovf_reg       <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    box_t out_box;
    logic out_found;
    assign out_found = (kept_n_reg != '0);
    assign out_box = out_found ? kept_box_reg[emit_reg[SW-1:0]] : '0;

    assign m_axis_tvalid = out_valid_reg && (state_reg == ST_EMIT);
    assign m_axis_tdata  = {out_box.sc, out_box.h, out_box.w, out_box.cy, out_box.cx};
    assign m_axis_tuser  = {ovf_reg, out_found};
    assign m_axis_tlast  = !out_found || (emit_reg + KW'(1) == kept_n_reg);

endmodule

// ===== src/bfnms_iou.sv =====
// ----------------------------------------------------------------------------
// bfnms_iou: overlap test unit
// Decides in a sequence of steps whether box a is suppressed by box b, with one
// shared multiplier used for the intersection and both areas in turn.
// ----------------------------------------------------------------------------
module bfnms_iou
    import bfnms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  box_t       box_a,
    input  box_t       box_b,
    input  logic [7:0] iou_limit,
    output logic       done,
    output logic       suppressed
);

    logic [2:0]  step_reg, step_next;
    logic [15:0] iw_reg, ih_reg;
    logic [31:0] prod_reg;
    logic [31:0] inter_reg;
    logic [32:0] area_reg;
    logic [15:0] iw_c, ih_c;
    logic [15:0] mul_a, mul_b;
    logic [31:0] mul_p;
    logic signed [34:0] uni_s;
    logic [42:0] lhs, rhs;

    // Clipped intersection length on one axis, in 1/32 pixel.
    function automatic logic [15:0] overlap(input logic [13:0] ca, input logic [13:0] sa,
                                            input logic [13:0] cb, input logic [13:0] sb);
        logic signed [17:0] a_hi, a_lo, b_hi, b_lo, hi, lo, d;
        begin
            a_hi = $signed({3'b0, ca, 1'b0}) + $signed({4'b0, sa});
            a_lo = $signed({3'b0, ca, 1'b0}) - $signed({4'b0, sa});
            b_hi = $signed({3'b0, cb, 1'b0}) + $signed({4'b0, sb});
            b_lo = $signed({3'b0, cb, 1'b0}) - $signed({4'b0, sb});
            hi = (a_hi < b_hi) ? a_hi : b_hi;
            lo = (a_lo > b_lo) ? a_lo : b_lo;
            d = hi - lo;
            overlap = d[17] ? 16'd0 : d[15:0];
        end
    endfunction

    assign iw_c = overlap(box_a.cx, box_a.w, box_b.cx, box_b.w);
    assign ih_c = overlap(box_a.cy, box_a.h, box_b.cy, box_b.h);

    always_comb
    begin
        case (step_reg)
            3'd1:    begin mul_a = iw_reg;            mul_b = ih_reg;            end
            3'd2:    begin mul_a = {2'b0, box_a.w};   mul_b = {2'b0, box_a.h};   end
            default: begin mul_a = {2'b0, box_b.w};   mul_b = {2'b0, box_b.h};   end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Areas are scaled by 4 to match the doubled coordinate span.
    assign uni_s = $signed({2'b0, area_reg}) + $signed({1'b0, prod_reg, 2'b0})
                   - $signed({3'b0, inter_reg});
    assign lhs = {3'b0, inter_reg, 8'b0};
    assign rhs = 43'(iou_limit) * 43'(uni_s[34:0]);

    always_comb
    begin
        step_next = step_reg;
        if (start)
        begin
            step_next = 3'd1;
        end
        else if (step_reg != 3'd0)
        begin
            step_next = (step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (step_reg)
            3'd0:    begin iw_reg <= iw_c; ih_reg <= ih_c; end
            3'd1:    inter_reg <= mul_p;
            3'd2:    area_reg <= {mul_p[30:0], 2'b0};
            3'd3:    prod_reg <= mul_p;
            3'd4:    suppressed <= !uni_s[34] && (uni_s != '0) && (lhs > rhs);
            default: ;
        endcase
    end

    assign done = (step_reg == 3'd5);

endmodule
